// File: design/cwfr_pkg.sv
package cwfr_pkg;

	// window geometry
	localparam int unsigned WIN_LEN   = 11;
	localparam logic [3:0]  BODY_LAST = 4'd9;    // index of the last body byte
	localparam logic [3:0]  CHECK_POS = 4'd10;   // newest byte, holds the check value
	localparam logic [2:0]  REPLY_LAST = 3'd6;   // index of the reply check byte

	// CRC-8, polynomial x^8 + x^2 + x + 1, MSB first
	localparam logic [7:0] CRC_POLY = 8'h07;

	// register reset values
	localparam logic [7:0] ALIGN_THR_RST = 8'd250;
	localparam logic [7:0] MANEUVER_RST  = 8'd1;

	// register indexes (paddr[2])
	localparam logic REG_ALIGN_THR = 1'b0;
	localparam logic REG_MANEUVER  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CRC,
		ST_CHECK,
		ST_EMIT
	} state_t;

	// one byte through the CRC register: 8 shift/xor steps
	function automatic logic [7:0] crc8_byte(input logic [7:0] c_in);
		logic [7:0] c;
		c = c_in;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: design/crc8_window_frame_responder_top.sv
// Byte-stream frame responder. Every byte accepted on rx shifts into an
// 11-byte window (cleared at reset); a byte-wide CRC-8 unit (poly 0x07, init 0)
// then runs over the oldest ten bytes, one byte a cycle, and the result is
// compared with the newest byte. A mismatch bumps bad_checks and gives one
// result with is_reply low. A match bumps good_frames, updates adcs/engine/led
// from the command and alignment bytes, and gives seven reply bytes:
// timestamp (LSB first), engine, adcs and a CRC-8 over those six, which the
// same CRC unit builds as the bytes leave. rx_stall is high from acceptance
// until the last result of the item has been taken, so no new byte is taken
// while an item is in progress. An item passes through the accepting cycle,
// ten passes through the shared CRC unit, one compare step and its results,
// one result per cycle while res_stall is low.
// Configuration registers (APB, 32-bit): 0x0 alignment_threshold, 0x4
// maneuver_code; write only while the block is idle.
module crc8_window_frame_responder_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte input
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_data,
	// results
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  reply_byte,
	output logic        is_reply,
	output logic        last_of_run,
	output logic        engine_on,
	output logic        adcs_on,
	output logic        led_level,
	output logic [31:0] good_frames,
	output logic [31:0] bad_checks
);

	cwfr_pkg::state_t state_q, state_nxt;

	logic [7:0]  win_q [cwfr_pkg::WIN_LEN];
	logic [3:0]  idx_q;
	logic [2:0]  k_q;
	logic [7:0]  crc_q;
	logic [7:0]  crc_next;
	logic [7:0]  unit_in;
	logic [7:0]  next_byte;
	logic [7:0]  reply_byte_q;
	logic        is_reply_q;
	logic        last_q;
	logic        engine_q;
	logic        adcs_q;
	logic        led_q;
	logic [31:0] good_q;
	logic [31:0] bad_q;
	logic [7:0]  align_thr_q;
	logic [7:0]  maneuver_q;
	logic        adcs_new;
	logic        engine_new;
	logic        rx_acc;
	logic        res_acc;
	logic        cfg_wr;

	// APB register file
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_thr_q <= cwfr_pkg::ALIGN_THR_RST;
			maneuver_q  <= cwfr_pkg::MANEUVER_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				cwfr_pkg::REG_ALIGN_THR: align_thr_q <= pwdata[7:0];
				cwfr_pkg::REG_MANEUVER:  maneuver_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cwfr_pkg::REG_ALIGN_THR: prdata = {24'd0, align_thr_q};
			cwfr_pkg::REG_MANEUVER:  prdata = {24'd0, maneuver_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cwfr_pkg::ST_IDLE:  if (rx_valid) state_nxt = cwfr_pkg::ST_CRC;
			cwfr_pkg::ST_CRC:   if (idx_q == cwfr_pkg::BODY_LAST) state_nxt = cwfr_pkg::ST_CHECK;
			cwfr_pkg::ST_CHECK: state_nxt = cwfr_pkg::ST_EMIT;
			cwfr_pkg::ST_EMIT:  if (!res_stall && last_q) state_nxt = cwfr_pkg::ST_IDLE;
			default:            state_nxt = cwfr_pkg::ST_IDLE;
		endcase
	end

	// state outputs: handshakes and the CRC unit's operand
	always_comb begin
		unique case (state_q)
			cwfr_pkg::ST_IDLE: begin
				rx_stall  = 1'b0;
				res_valid = 1'b0;
				unit_in   = win_q[idx_q];
			end
			cwfr_pkg::ST_EMIT: begin
				rx_stall  = 1'b1;
				res_valid = 1'b1;
				unit_in   = reply_byte_q;
			end
			default: begin
				rx_stall  = 1'b1;
				res_valid = 1'b0;
				unit_in   = win_q[idx_q];
			end
		endcase
	end

	assign rx_acc  = rx_valid & ~rx_stall;
	assign res_acc = res_valid & ~res_stall;

	// shared byte-wide CRC unit
	assign crc_next = cwfr_pkg::crc8_byte(crc_q ^ unit_in);

	// frame decode
	assign adcs_new   = (win_q[9] == maneuver_q);
	assign engine_new = adcs_new && (win_q[8] >= align_thr_q);

	// reply byte that follows reply byte k_q
	always_comb begin
		unique case (k_q)
			3'd0:    next_byte = win_q[5];
			3'd1:    next_byte = win_q[6];
			3'd2:    next_byte = win_q[7];
			3'd3:    next_byte = {7'd0, engine_q};
			3'd4:    next_byte = {7'd0, adcs_q};
			default: next_byte = crc_next;
		endcase
	end

	// datapath and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cwfr_pkg::ST_IDLE;
			for (int i = 0; i < cwfr_pkg::WIN_LEN; i++) begin
				win_q[i] <= 8'd0;
			end
			idx_q        <= 4'd0;
			k_q          <= 3'd0;
			crc_q        <= 8'd0;
			reply_byte_q <= 8'd0;
			is_reply_q   <= 1'b0;
			last_q       <= 1'b0;
			engine_q     <= 1'b0;
			adcs_q       <= 1'b0;
			led_q        <= 1'b1;
			good_q       <= 32'd0;
			bad_q        <= 32'd0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				cwfr_pkg::ST_IDLE: begin
					// shift the new byte in, oldest drops out
					if (rx_acc) begin
						for (int i = 0; i < cwfr_pkg::WIN_LEN - 1; i++) begin
							win_q[i] <= win_q[i+1];
						end
						win_q[cwfr_pkg::WIN_LEN-1] <= rx_data;
						idx_q <= 4'd0;
						crc_q <= 8'd0;
					end
				end
				cwfr_pkg::ST_CRC: begin
					crc_q <= crc_next;
					idx_q <= idx_q + 4'd1;
				end
				cwfr_pkg::ST_CHECK: begin
					if (crc_q != win_q[cwfr_pkg::CHECK_POS]) begin
						bad_q        <= bad_q + 32'd1;
						reply_byte_q <= 8'd0;
						is_reply_q   <= 1'b0;
						last_q       <= 1'b1;
					end else begin
						good_q       <= good_q + 32'd1;
						adcs_q       <= adcs_new;
						engine_q     <= engine_new;
						led_q        <= ~engine_new;
						crc_q        <= 8'd0;
						k_q          <= 3'd0;
						reply_byte_q <= win_q[4];
						is_reply_q   <= 1'b1;
						last_q       <= 1'b0;
					end
				end
				cwfr_pkg::ST_EMIT: begin
					// fold the departing byte into the reply CRC, load the next
					if (res_acc && !last_q) begin
						crc_q        <= crc_next;
						k_q          <= k_q + 3'd1;
						reply_byte_q <= next_byte;
						last_q       <= ((k_q + 3'd1) == cwfr_pkg::REPLY_LAST);
					end
				end
				default: ;
			endcase
		end
	end

	assign reply_byte  = reply_byte_q;
	assign is_reply    = is_reply_q;
	assign last_of_run = last_q;
	assign engine_on   = engine_q;
	assign adcs_on     = adcs_q;
	assign led_level   = led_q;
	assign good_frames = good_q;
	assign bad_checks  = bad_q;

endmodule

// File: tb/sv/tb_crc8_window_frame_responder_top.sv
module tb_crc8_window_frame_responder_top;
	import cwfr_pkg::*;

	// one result as the block presents it
	typedef struct packed {
		logic [7:0]  data;
		logic        reply;
		logic        last;
		logic        engine;
		logic        adcs;
		logic        led;
		logic [31:0] good;
		logic [31:0] bad;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_data = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [7:0]  reply_byte;
	logic        is_reply;
	logic        last_of_run;
	logic        engine_on;
	logic        adcs_on;
	logic        led_level;
	logic [31:0] good_frames;
	logic [31:0] bad_checks;

	crc8_window_frame_responder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_data(rx_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.reply_byte(reply_byte),
		.is_reply(is_reply),
		.last_of_run(last_of_run),
		.engine_on(engine_on),
		.adcs_on(adcs_on),
		.led_level(led_level),
		.good_frames(good_frames),
		.bad_checks(bad_checks)
	);

	// predicted state of the responder
	logic [7:0]  win [WIN_LEN];
	logic [31:0] good_cnt;
	logic [31:0] bad_cnt;
	logic        engine_st;
	logic        adcs_st;
	logic        led_st;
	logic [7:0]  thr_reg;
	logic [7:0]  man_reg;
	frame_result_t due_results [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int err_count = 0;
	int sent_items = 0;

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// one byte through a CRC-8 register, poly 0x07, MSB first
	function automatic logic [7:0] crc8_add(input logic [7:0] c, input logic [7:0] d);
		logic [7:0] r;
		r = c ^ d;
		repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		return r;
	endfunction

	// CRC over ten window bytes starting at first
	function automatic logic [7:0] window_crc(input int first);
		logic [7:0] c;
		c = 8'h00;
		for (int k = 0; k < 10; k++) c = crc8_add(c, win[first + k]);
		return c;
	endfunction

	// alignment byte at, just under, or anywhere around the threshold
	function automatic logic [7:0] near_threshold();
		case ($urandom_range(2))
			0: return thr_reg;
			1: return thr_reg - 8'd1;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic model_reset();
		foreach (win[k]) win[k] = 8'h00;
		good_cnt = '0;
		bad_cnt = '0;
		engine_st = 1'b0;
		adcs_st = 1'b0;
		led_st = 1'b1;
		thr_reg = ALIGN_THR_RST;
		man_reg = MANEUVER_RST;
	endtask

	// shift one byte into the window and queue the results it causes
	task automatic shift_in_byte(input logic [7:0] b);
		logic [7:0] crc;
		logic [7:0] out_b;
		for (int k = 0; k < WIN_LEN - 1; k++) win[k] = win[k + 1];
		win[WIN_LEN - 1] = b;
		if (window_crc(0) != win[WIN_LEN - 1]) begin
			bad_cnt++;
			due_results.push_back('{8'h00, 1'b0, 1'b1, engine_st, adcs_st, led_st,
				good_cnt, bad_cnt});
		end else begin
			good_cnt++;
			adcs_st = (win[9] == man_reg);
			engine_st = adcs_st && (win[8] >= thr_reg);
			led_st = !engine_st;
			crc = 8'h00;
			for (int k = 0; k <= REPLY_LAST; k++) begin
				if (k < 4)
					out_b = win[4 + k];
				else if (k == 4)
					out_b = {7'd0, engine_st};
				else if (k == 5)
					out_b = {7'd0, adcs_st};
				else
					out_b = crc;
				crc = crc8_add(crc, out_b);
				due_results.push_back('{out_b, 1'b1, k == REPLY_LAST, engine_st, adcs_st,
					led_st, good_cnt, bad_cnt});
			end
		end
	endtask

	task automatic log_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("ERROR: %s", msg);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			log_error($sformatf("%s expected %h got %h", what, want, got));
	endtask

	// offer one item and return at the edge that takes it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_data <= b;
		shift_in_byte(b);
		sent_items++;
		@(negedge clk);
		while (rx_stall) @(negedge clk);
		@(posedge clk);
	endtask

	// alignment, command and check byte: the window's older bytes form the rest
	task automatic send_tail(input logic [7:0] align, input logic [7:0] cmd,
			input logic [7:0] flip);
		send_byte(align);
		send_byte(cmd);
		send_byte(window_crc(1) ^ flip);
	endtask

	task automatic send_frame(input logic [31:0] stamp, input logic [7:0] align,
			input logic [7:0] cmd);
		repeat (4) send_byte(8'($urandom_range(255)));
		for (int k = 0; k < 4; k++) send_byte(stamp[8 * k +: 8]);
		send_tail(align, cmd, 8'h00);
	endtask

	// wait until every expected result is in and the block has gone quiet
	task automatic settle();
		rx_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	// one APB transfer; a read is checked against the predicted register
	task automatic reg_access(input logic wr, input logic sel, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {sel, 2'b00};
		pwdata <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		if (!wr)
			check_field("prdata", {24'h0, (sel == REG_ALIGN_THR) ? thr_reg : man_reg},
				prdata);
		@(posedge clk);
		if (wr) begin
			if (sel == REG_ALIGN_THR)
				thr_reg = val;
			else
				man_reg = val;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] thr, input logic [7:0] man);
		settle();
		reg_access(1'b1, REG_ALIGN_THR, thr);
		reg_access(1'b1, REG_MANEUVER, man);
		reg_access(1'b0, REG_ALIGN_THR, 8'h00);
		reg_access(1'b0, REG_MANEUVER, 8'h00);
	endtask

	// the cleared window is already a valid frame; then a plain mismatch
	task automatic test_zero_window();
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// decode of alignment and command under the reset settings, and a corrupted check byte
	task automatic test_frame_decode();
		send_frame(32'hFF00A55A, ALIGN_THR_RST, MANEUVER_RST);
		send_tail(ALIGN_THR_RST - 8'd1, MANEUVER_RST, 8'h00);
		send_tail(8'hFF, 8'h00, 8'h00);
		send_tail(8'h00, MANEUVER_RST, 8'h80);
	endtask

	// register extremes
	task automatic test_config_extremes();
		set_config(8'h00, 8'h00);
		send_tail(8'h00, 8'h00, 8'h00);
		set_config(8'hFF, 8'hFF);
		send_tail(8'hFF, 8'hFF, 8'h00);
		send_tail(8'hFE, 8'hFF, 8'h00);
	endtask

	// mostly well-formed frames with random content, some corrupt, some noise
	task automatic test_random_phase(input int idle, input int stall, input int n_items);
		int stop_at;
		int pick;
		set_config(8'($urandom_range(255)), 8'($urandom_range(255)));
		send_idle_pct = idle;
		stall_pct = stall;
		stop_at = sent_items + n_items;
		while (sent_items < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 40)
				send_frame($urandom, near_threshold(),
					$urandom_range(1) ? man_reg : 8'($urandom_range(255)));
			else if (pick < 60)
				send_tail(near_threshold(),
					$urandom_range(1) ? man_reg : 8'($urandom_range(255)), 8'h00);
			else if (pick < 75)
				send_byte(window_crc(1));
			else if (pick < 88)
				send_byte(window_crc(1) ^ (8'h01 << $urandom_range(7)));
			else
				send_byte(8'($urandom_range(255)));
		end
		settle();
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	// result stall
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// result checker: the item is taken at the coming edge
	always @(negedge clk) begin
		frame_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (due_results.size() == 0) begin
				log_error($sformatf("unexpected result, reply_byte %h", reply_byte));
			end else begin
				want = due_results.pop_front();
				check_field("reply_byte", want.data, reply_byte);
				check_field("is_reply", want.reply, is_reply);
				check_field("last_of_run", want.last, last_of_run);
				check_field("engine_on", want.engine, engine_on);
				check_field("adcs_on", want.adcs, adcs_on);
				check_field("led_level", want.led, led_level);
				check_field("good_frames", want.good, good_frames);
				check_field("bad_checks", want.bad, bad_checks);
			end
		end
	end

	// sequence
	initial begin
		model_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_window();
		test_frame_decode();
		test_config_extremes();
		test_random_phase(0, 0, 72);
		test_random_phase(71, 0, 72);
		test_random_phase(0, 71, 72);
		test_random_phase(14, 14, 72);
		settle();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
design/cwfr_pkg.sv
design/crc8_window_frame_responder_top.sv
tb/sv/tb_crc8_window_frame_responder_top.sv
